// ----- sv/snxc_pkg.sv -----
// types, constants and the hex digit table for the sentence receiver
// no dependencies; used by every module of the block by scoped names
package snxc_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISMATCH  = 3'd1;
    localparam logic [2:0] ST_NO_HEADER = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_LINK      = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_BODY  = 6'b000010,
        PH_HEX1  = 6'b000100,
        PH_HEX2  = 6'b001000,
        PH_TAIL1 = 6'b010000,
        PH_TAIL2 = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       link_error;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       frame_end;
        logic [2:0] status;
        logic [7:0] frame_length;
    } out_beat_t;

    typedef struct packed {
        logic      push;
        out_beat_t item;
    } push_t;

    // uppercase ascii hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h41;
            4'hB: c = 8'h42;
            4'hC: c = 8'h43;
            4'hD: c = 8'h44;
            4'hE: c = 8'h45;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/snxc_front.sv -----
// front end: takes received beats, tracks the sentence phase and checksum,
// and produces result beats; depends on snxc_pkg
module snxc_front #(
    parameter int MAX_CHARS = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               accept,
    input  snxc_pkg::in_beat_t beat,
    output snxc_pkg::push_t    push_out
);

    localparam logic [7:0] MAX_LIM = 8'(MAX_CHARS);

    logic             mode_reg, mode_next;
    snxc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       hex_reg, hex_next;
    logic             mism_reg, mism_next;
    logic [7:0]       cnt_inc;
    logic [7:0]       xor_upd;
    snxc_pkg::phase_t start_phase;

    always_comb begin
        mode_next   = mode_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        hex_next    = hex_reg;
        mism_next   = mism_reg;
        push_out    = '0;
        cnt_inc     = count_reg + 8'd1;
        xor_upd     = xor_reg ^ beat.rx_byte;
        start_phase = mode_reg ? snxc_pkg::PH_BODY : snxc_pkg::PH_HUNT;

        if (accept) begin
            if (beat.link_error) begin
                push_out.push           = 1'b1;
                push_out.item.frame_end = 1'b1;
                push_out.item.status    = snxc_pkg::ST_LINK;
                phase_next = start_phase;
                count_next = '0;
                xor_next   = '0;
                hex_next   = '0;
                mism_next  = 1'b0;
            end else begin
                case (phase_reg)
                    snxc_pkg::PH_HUNT: begin
                        if (beat.rx_byte == snxc_pkg::CHAR_DOLLAR) begin
                            phase_next = snxc_pkg::PH_BODY;
                            count_next = '0;
                            xor_next   = '0;
                        end else if (cnt_inc >= MAX_LIM) begin
                            push_out.push           = 1'b1;
                            push_out.item.frame_end = 1'b1;
                            push_out.item.status    = snxc_pkg::ST_NO_HEADER;
                            phase_next = start_phase;
                            count_next = '0;
                            xor_next   = '0;
                            hex_next   = '0;
                            mism_next  = 1'b0;
                        end else begin
                            count_next = cnt_inc;
                        end
                    end
                    snxc_pkg::PH_BODY: begin
                        if (!mode_reg && beat.rx_byte == snxc_pkg::CHAR_STAR) begin
                            phase_next = snxc_pkg::PH_HEX1;
                        end else begin
                            push_out.push           = 1'b1;
                            push_out.item.data_byte = beat.rx_byte;
                            push_out.item.is_data   = 1'b1;
                            count_next = cnt_inc;
                            xor_next   = xor_upd;
                            if (mode_reg && beat.rx_byte == snxc_pkg::CHAR_LF) begin
                                push_out.item.frame_end    = 1'b1;
                                push_out.item.status       = snxc_pkg::ST_OK;
                                push_out.item.frame_length = cnt_inc;
                                phase_next = start_phase;
                                count_next = '0;
                                xor_next   = '0;
                                hex_next   = '0;
                                mism_next  = 1'b0;
                            end else if (cnt_inc >= MAX_LIM) begin
                                push_out.item.frame_end = 1'b1;
                                push_out.item.status    = snxc_pkg::ST_TOO_LONG;
                                phase_next = start_phase;
                                count_next = '0;
                                xor_next   = '0;
                                hex_next   = '0;
                                mism_next  = 1'b0;
                            end
                        end
                    end
                    snxc_pkg::PH_HEX1: begin
                        hex_next   = beat.rx_byte;
                        phase_next = snxc_pkg::PH_HEX2;
                    end
                    snxc_pkg::PH_HEX2: begin
                        mism_next  = !(hex_reg == snxc_pkg::hex_char(xor_reg[7:4])
                                       && beat.rx_byte == snxc_pkg::hex_char(xor_reg[3:0]));
                        phase_next = snxc_pkg::PH_TAIL1;
                    end
                    snxc_pkg::PH_TAIL1: begin
                        phase_next = snxc_pkg::PH_TAIL2;
                    end
                    default: begin
                        push_out.push           = 1'b1;
                        push_out.item.frame_end = 1'b1;
                        push_out.item.status    = mism_reg ? snxc_pkg::ST_MISMATCH
                                                           : snxc_pkg::ST_OK;
                        push_out.item.frame_length = mism_reg ? 8'd0 : count_reg;
                        phase_next = start_phase;
                        count_next = '0;
                        xor_next   = '0;
                        hex_next   = '0;
                        mism_next  = 1'b0;
                    end
                endcase
            end
        end

        // mode write drops the frame in progress
        if (cfg_wr_en) begin
            mode_next  = cfg_wr_data;
            phase_next = cfg_wr_data ? snxc_pkg::PH_BODY : snxc_pkg::PH_HUNT;
            count_next = '0;
            xor_next   = '0;
            hex_next   = '0;
            mism_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            phase_reg <= snxc_pkg::PH_HUNT;
            count_reg <= '0;
            xor_reg   <= '0;
            hex_reg   <= '0;
            mism_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            hex_reg   <= hex_next;
            mism_reg  <= mism_next;
        end
    end

endmodule

// ----- sv/snxc_queue.sv -----
// result queue and output side: holds result beats from the front end
// until the downstream side takes them; depends on snxc_pkg
module snxc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  snxc_pkg::push_t     push_in,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output snxc_pkg::out_beat_t m_data
);

    localparam logic [snxc_pkg::QUEUE_AW:0] DEPTH_CNT =
        (snxc_pkg::QUEUE_AW + 1)'(snxc_pkg::QUEUE_DEPTH);

    snxc_pkg::out_beat_t           mem_reg [snxc_pkg::QUEUE_DEPTH];
    logic [snxc_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [snxc_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [snxc_pkg::QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                          do_pop;

    assign full    = (cnt_reg == DEPTH_CNT);
    assign m_valid = (cnt_reg != '0);
    assign m_data  = mem_reg[rd_ptr_reg];
    assign do_pop  = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_in.push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push_in.push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push_in.push) begin
            mem_reg[wr_ptr_reg] <= push_in.item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- sv/sentence_receiver_xor_check.sv -----
// top level of the sentence receiver with xor checksum
// depends on snxc_pkg, snxc_front and snxc_queue
//
// Takes one received character per beat on s_ and cuts the stream into frames: in mode 0
// '$'..'*' sentences checked against two uppercase hex digits, in mode 1 lines ended by LF.
// Each payload character comes out as one m_ beat; frame ends carry status and length.
// One character is accepted every clock cycle while the four-entry result queue has room;
// each result is registered in that queue before it appears on m_. Writing cfg_wr_data
// with cfg_wr_en restarts the receiver in the chosen mode and must be done while idle.
module sentence_receiver_xor_check #(
    parameter int MAX_CHARS = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  snxc_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output snxc_pkg::out_beat_t m_data
);

    snxc_pkg::push_t push;
    logic            q_full;
    logic            accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    snxc_front #(
        .MAX_CHARS(MAX_CHARS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .accept     (accept),
        .beat       (s_data),
        .push_out   (push)
    );

    snxc_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push_in(push),
        .full   (q_full),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

// ----- sv/snxc_checker.sv -----
// port-level checker for the sentence receiver, bound to the top level
// depends on snxc_pkg and sentence_receiver_xor_check
module snxc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input snxc_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input snxc_pkg::out_beat_t m_data
);

    // output stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a link error beat always yields a result
    a_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.link_error |=> m_valid)
        else $error("link error produced no result");

    // a beat that does not end a frame carries payload
    a_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.frame_end |-> m_data.is_data && m_data.status == snxc_pkg::ST_OK)
        else $error("non-ending beat without payload");

    // a length is shown only on an ok frame end
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_length != 8'd0
        |-> m_data.frame_end && m_data.status == snxc_pkg::ST_OK)
        else $error("length on a non-ok beat");

endmodule

bind sentence_receiver_xor_check snxc_checker u_snxc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

// ----- dv/snxc_frame_checker.sv -----
`timescale 1ns / 1ps
// checker for the sentence receiver: follows the character stream, predicts each result beat
// and compares it with what leaves m_; depends on snxc_pkg

module snxc_frame_checker #(
    parameter int MAX_CHARS = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  snxc_pkg::in_beat_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  snxc_pkg::out_beat_t m_data,
    output int                  fail_count,
    output int                  pending
);

    logic                line_mode;
    snxc_pkg::phase_t    rx_phase;
    logic [7:0]          char_total;
    logic [7:0]          xor_sum;
    logic [7:0]          hex_hold;
    snxc_pkg::out_beat_t due_beats[$];
    int                  errors = 0;

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic restart_frame();
        rx_phase   = line_mode ? snxc_pkg::PH_BODY : snxc_pkg::PH_HUNT;
        char_total = '0;
        xor_sum    = '0;
        hex_hold   = '0;
    endtask

    task automatic push_result(input logic [7:0] ch, input logic carries, input logic ends,
                               input logic [2:0] st, input logic [7:0] len);
        snxc_pkg::out_beat_t b;
        b.data_byte    = carries ? ch : 8'h00;
        b.is_data      = carries;
        b.frame_end    = ends;
        b.status       = ends ? st : snxc_pkg::ST_OK;
        b.frame_length = (ends && st == snxc_pkg::ST_OK) ? len : 8'h00;
        due_beats.push_back(b);
    endtask

    task automatic predict_char(input snxc_pkg::in_beat_t b);
        logic [7:0] ch;
        ch = b.rx_byte;
        if (b.link_error) begin
            push_result(8'h00, 1'b0, 1'b1, snxc_pkg::ST_LINK, 8'h00);
            restart_frame();
        end else begin
            case (rx_phase)
                snxc_pkg::PH_HUNT: begin
                    if (ch == snxc_pkg::CHAR_DOLLAR) begin
                        rx_phase   = snxc_pkg::PH_BODY;
                        char_total = '0;
                        xor_sum    = '0;
                    end else begin
                        char_total = char_total + 8'd1;
                        if (char_total >= MAX_CHARS) begin
                            push_result(8'h00, 1'b0, 1'b1, snxc_pkg::ST_NO_HEADER, 8'h00);
                            restart_frame();
                        end
                    end
                end
                snxc_pkg::PH_BODY: begin
                    if (!line_mode && ch == snxc_pkg::CHAR_STAR) begin
                        rx_phase = snxc_pkg::PH_HEX1;
                    end else begin
                        char_total = char_total + 8'd1;
                        xor_sum    = xor_sum ^ ch;
                        if (line_mode && ch == snxc_pkg::CHAR_LF) begin
                            push_result(ch, 1'b1, 1'b1, snxc_pkg::ST_OK, char_total);
                            restart_frame();
                        end else if (char_total >= MAX_CHARS) begin
                            push_result(ch, 1'b1, 1'b1, snxc_pkg::ST_TOO_LONG, 8'h00);
                            restart_frame();
                        end else begin
                            push_result(ch, 1'b1, 1'b0, snxc_pkg::ST_OK, 8'h00);
                        end
                    end
                end
                snxc_pkg::PH_HEX1: begin
                    hex_hold = ch;
                    rx_phase = snxc_pkg::PH_HEX2;
                end
                snxc_pkg::PH_HEX2: begin
                    hex_hold = (hex_hold == nibble_char(xor_sum[7:4])
                                && ch == nibble_char(xor_sum[3:0]))
                               ? 8'(snxc_pkg::ST_OK) : 8'(snxc_pkg::ST_MISMATCH);
                    rx_phase = snxc_pkg::PH_TAIL1;
                end
                snxc_pkg::PH_TAIL1: begin
                    rx_phase = snxc_pkg::PH_TAIL2;
                end
                default: begin
                    push_result(8'h00, 1'b0, 1'b1,
                                (hex_hold == 8'(snxc_pkg::ST_OK)) ? snxc_pkg::ST_OK
                                                                  : snxc_pkg::ST_MISMATCH,
                                char_total);
                    restart_frame();
                end
            endcase
        end
    endtask

    task automatic check_beat(input snxc_pkg::out_beat_t got);
        snxc_pkg::out_beat_t want;
        if (due_beats.size() == 0) begin
            report_mismatch("beat with nothing pending, status", int'(got.status), 0);
        end else begin
            want = due_beats.pop_front();
            if (got.data_byte !== want.data_byte)
                report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
            if (got.is_data !== want.is_data)
                report_mismatch("is_data", int'(got.is_data), int'(want.is_data));
            if (got.frame_end !== want.frame_end)
                report_mismatch("frame_end", int'(got.frame_end), int'(want.frame_end));
            if (got.status !== want.status)
                report_mismatch("status", int'(got.status), int'(want.status));
            if (got.frame_length !== want.frame_length)
                report_mismatch("frame_length", int'(got.frame_length),
                                int'(want.frame_length));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_mode = 1'b0;
            restart_frame();
            due_beats.delete();
        end else begin
            // a result leaves through the result queue only after its character is taken, so check before predicting
            if (m_valid && m_ready)
                check_beat(m_data);
            if (cfg_wr_en) begin
                line_mode = cfg_wr_data;
                restart_frame();
            end
            if (s_valid && s_ready)
                predict_char(s_data);
        end
        pending    <= due_beats.size();
        fail_count <= errors;
    end

endmodule

// ----- dv/sentence_receiver_xor_check_test.sv -----
`timescale 1ns / 1ps
// testbench top for the sentence receiver: drives sentences, lines, noise and link errors
// with bursty input and a stalling output; depends on snxc_pkg and snxc_frame_checker

module sentence_receiver_xor_check_test;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_BEATS = 64;

    localparam int FLAW_NONE  = 0;
    localparam int FLAW_LOWER = 1;
    localparam int FLAW_DIGIT = 2;
    localparam int FLAW_TAIL  = 3;
    localparam int FLAW_CUT   = 4;

    localparam int RX_OPEN  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_COMB  = 2;
    localparam int RX_CHOKE = 3;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    snxc_pkg::in_beat_t  s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    snxc_pkg::out_beat_t m_data;
    int                  fail_count;
    int                  pending;

    logic [7:0] frame_bytes[$];
    int         beats_sent  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    int         rx_style    = RX_OPEN;
    int         rx_left     = 0;
    int         cycle_no    = 0;

    sentence_receiver_xor_check u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    snxc_frame_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(RX_OPEN, RX_CHOKE);
            rx_left  = $urandom_range(20, 150);
        end
        rx_left  = rx_left - 1;
        cycle_no = cycle_no + 1;
        case (rx_style)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            RX_COMB: m_ready <= (cycle_no % 3 != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [7:0] ch, input logic err);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        s_valid <= 1'b1;
        s_data  <= '{rx_byte: ch, link_error: err};
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        beats_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic set_mode(input logic line_mode);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= line_mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic build_sentence(input int len, input int flaw);
        logic [7:0] sum;
        logic [7:0] ch;
        string      hx;
        sum = '0;
        frame_bytes.delete();
        frame_bytes.push_back(snxc_pkg::CHAR_DOLLAR);
        repeat (len) begin
            ch = 8'($urandom);
            if (ch == snxc_pkg::CHAR_STAR)
                ch = 8'h2B;
            sum = sum ^ ch;
            frame_bytes.push_back(ch);
        end
        hx = (flaw == FLAW_LOWER) ? $sformatf("%02x", sum) : $sformatf("%02X", sum);
        if (flaw == FLAW_DIGIT)
            hx[$urandom_range(0, 1)] = 8'($urandom_range(1, 255));
        frame_bytes.push_back(snxc_pkg::CHAR_STAR);
        frame_bytes.push_back(hx[0]);
        frame_bytes.push_back(hx[1]);
        if (flaw == FLAW_TAIL) begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
        end else begin
            frame_bytes.push_back(CHAR_CR);
            frame_bytes.push_back(snxc_pkg::CHAR_LF);
        end
    endtask

    task automatic build_line(input int len);
        logic [7:0] ch;
        frame_bytes.delete();
        repeat (len) begin
            ch = 8'($urandom);
            if (ch == snxc_pkg::CHAR_LF)
                ch = 8'h0B;
            frame_bytes.push_back(ch);
        end
        frame_bytes.push_back(snxc_pkg::CHAR_LF);
    endtask

    // a cut frame has one of its characters replaced by a link error and ends there
    task automatic send_frame(input int flaw);
        int cut;
        cut = (flaw == FLAW_CUT) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
        foreach (frame_bytes[i]) begin
            if (i == cut) begin
                send_beat(8'($urandom), 1'b1);
                break;
            end
            send_beat(frame_bytes[i], 1'b0);
        end
    endtask

    task automatic send_noise(input int n, input logic quiet);
        logic [7:0] ch;
        repeat (n) begin
            ch = 8'($urandom);
            if (quiet && ch == snxc_pkg::CHAR_DOLLAR)
                ch = 8'h25;
            send_beat(ch, !quiet && $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        logic line_mode;
        int   phase_start;
        int   r;
        int   flaw;
        bit   drained;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        set_mode(1'b0);
        frame_bytes = '{snxc_pkg::CHAR_DOLLAR, 8'hFF, snxc_pkg::CHAR_STAR, 8'h46, 8'h46,
                        CHAR_CR, snxc_pkg::CHAR_LF};
        send_frame(FLAW_NONE);
        frame_bytes = '{snxc_pkg::CHAR_DOLLAR, snxc_pkg::CHAR_STAR, 8'h30, 8'h30,
                        CHAR_CR, snxc_pkg::CHAR_LF};
        send_frame(FLAW_NONE);
        frame_bytes = '{snxc_pkg::CHAR_DOLLAR, 8'hAB, snxc_pkg::CHAR_STAR, 8'h61, 8'h62,
                        CHAR_CR, snxc_pkg::CHAR_LF};
        send_frame(FLAW_NONE);
        send_beat(8'hFF, 1'b1);

        set_mode(1'b1);
        frame_bytes = '{8'h00, snxc_pkg::CHAR_LF};
        send_frame(FLAW_NONE);
        send_beat(8'h41, 1'b0);
        send_beat(8'h00, 1'b1);

        for (int p = 0; p < 6; p++) begin
            line_mode = p[0];
            set_mode(line_mode);
            case (p)
                0: send_noise(260, 1'b1);
                1: begin build_line(254); send_frame(FLAW_NONE); end
                2: begin build_sentence(256, FLAW_NONE); send_frame(FLAW_NONE); end
                3: begin build_line(258); send_frame(FLAW_NONE); end
                4: begin build_sentence(254, FLAW_NONE); send_frame(FLAW_NONE); end
                default: ;
            endcase
            phase_start = beats_sent;
            drained     = 1'b0;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if (!drained && beats_sent - phase_start >= PHASE_BEATS / 2) begin
                    drain_results();
                    drained = 1'b1;
                end
                r    = $urandom_range(0, 99);
                flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(FLAW_LOWER, FLAW_CUT)
                                                   : FLAW_NONE;
                if (r < 65) begin
                    if (line_mode) build_line($urandom_range(0, 12));
                    else           build_sentence($urandom_range(0, 12), flaw);
                    send_frame(flaw);
                end else if (r < 80) begin
                    send_noise($urandom_range(1, 6), 1'b0);
                end else if (r < 90) begin
                    if (line_mode) build_line($urandom_range(0, 4));
                    else           build_sentence($urandom_range(0, 4), FLAW_CUT);
                    send_frame(FLAW_CUT);
                end else if (r < 98) begin
                    if (line_mode) build_line($urandom_range(13, 40));
                    else           build_sentence($urandom_range(13, 40), flaw);
                    send_frame(flaw);
                end else if (r < 99) begin
                    drain_results();
                end else begin
                    if (line_mode) build_line($urandom_range(250, 258));
                    else           build_sentence($urandom_range(250, 258), FLAW_NONE);
                    send_frame(FLAW_NONE);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
